>>> hdl/sbir_pkg.sv
// ----------------------------------------------------------------------------
// sbir_pkg: shared types and constants for the serial boot image receiver
// Holds the event codes, the result bundle and the field widths.
// ----------------------------------------------------------------------------
package sbir_pkg;

   // address entry limits
   localparam int unsigned MAX_ADDRESS_DIGITS = 8;
   localparam int unsigned DIGIT_CNT_W        = $clog2(MAX_ADDRESS_DIGITS + 1);

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned EVENT_W = 3;

   // reset value of the default load address
   localparam logic [ADDR_W-1:0] DEFAULT_LOAD_ADDR_RST = 32'h0008_0000;

   // per-byte event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_CONSUMED = 3'd0,
      EV_STORE    = 3'd1,
      EV_ABORT    = 3'd2,
      EV_START    = 3'd3,
      EV_FAIL     = 3'd4
   } event_type;

   // one result transaction
   typedef struct packed {
      event_type             event_res;
      logic [ADDR_W-1:0]     target_address;
      logic [BYTE_W-1:0]     store_data;
   } result_type;

endpackage

>>> hdl/serial_boot_image_receiver.sv
// ----------------------------------------------------------------------------
// serial_boot_image_receiver: boot image receiver for a serial byte stream
// Parses a hex load address, a size/checksum header and the image payload,
// and reports one event per received byte.
//
//   channel   direction  ports               contents
//   req       in         req_t*              received byte
//   rsp       out        rsp_t*              event, address, store byte
//   csr       in         csr_wr_en/_data     default load address
//
// One byte per cycle while rsp_tready is high; a byte's result passes through
// the input register, then the result register, before it is presented.
// Reset clears the protocol state and loads the default address 0x80000.
// A stalled result holds in the result register while one more byte waits
// in the input register; the per-byte update sets the single-cycle rate.
// ----------------------------------------------------------------------------
module serial_boot_image_receiver (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: [31:0] target_address, [39:32] store_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // response: [2:0] event_res
   output logic [2:0]  rsp_tuser,
   // configuration: default load address
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic                               in_valid_ff;
   logic [sbir_pkg::BYTE_W-1:0]        in_byte_ff;
   logic                               out_valid_ff;
   sbir_pkg::result_type               out_result_ff;
   logic [sbir_pkg::ADDR_W-1:0]        default_addr_ff;
   sbir_pkg::result_type               step_result;
   logic                               advance;

   // move the held byte into the result register when it is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         default_addr_ff <= sbir_pkg::DEFAULT_LOAD_ADDR_RST;
      end else if (csr_wr_en) begin
         default_addr_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   sbir_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .rx_byte      (in_byte_ff),
      .default_addr (default_addr_ff),
      .result       (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.store_data, out_result_ff.target_address};
   assign rsp_tuser  = out_result_ff.event_res;

endmodule

>>> hdl/sbir_core.sv
// ----------------------------------------------------------------------------
// sbir_core: protocol state and per-byte update
// Holds the entry/header/payload state and computes the result of one byte.
// ----------------------------------------------------------------------------
module sbir_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [sbir_pkg::BYTE_W-1:0]   rx_byte,
   input  logic [sbir_pkg::ADDR_W-1:0]   default_addr,
   output sbir_pkg::result_type          result
);

   typedef enum logic [1:0] {
      PH_ENTRY   = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_REPORT  = 2'd3
   } phase_type;

   localparam logic [sbir_pkg::BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [sbir_pkg::BYTE_W-1:0] CH_ETX = 8'h03;
   localparam logic [sbir_pkg::BYTE_W-1:0] CH_BS  = 8'h08;
   localparam logic [sbir_pkg::BYTE_W-1:0] CH_DEL = 8'h7F;
   localparam logic [sbir_pkg::DIGIT_CNT_W-1:0] DIGITS_FULL =
      sbir_pkg::DIGIT_CNT_W'(sbir_pkg::MAX_ADDRESS_DIGITS);

   phase_type                           phase_ff,     phase_in;
   logic [sbir_pkg::ADDR_W-1:0]         entered_ff,   entered_in;
   logic [sbir_pkg::DIGIT_CNT_W-1:0]    digits_ff,    digits_in;
   logic [2:0]                          hdr_cnt_ff,   hdr_cnt_in;
   logic [31:0]                         size_ff,      size_in;
   logic [31:0]                         csum_ff,      csum_in;
   logic [31:0]                         pay_cnt_ff,   pay_cnt_in;

   logic [31:0]                         hdr_shift;
   logic                                hex_ok;
   logic [3:0]                          hex_val;

   // hex digit decode
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (rx_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(rx_byte - 8'h30);
      end else if (rx_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(rx_byte - 8'h57);
      end else if (rx_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(rx_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hdr_shift = {(hdr_cnt_ff[2] ? csum_ff[23:0] : size_ff[23:0]), rx_byte};

   // next state and result of one byte
   always_comb begin
      phase_in   = phase_ff;
      entered_in = entered_ff;
      digits_in  = digits_ff;
      hdr_cnt_in = hdr_cnt_ff;
      size_in    = size_ff;
      csum_in    = csum_ff;
      pay_cnt_in = pay_cnt_ff;
      result.event_res      = sbir_pkg::EV_CONSUMED;
      result.target_address = '0;
      result.store_data     = '0;

      case (phase_ff)
         PH_ENTRY: begin
            if (rx_byte == CH_LF) begin
               if (entered_ff == '0) begin
                  entered_in = default_addr;
               end
               phase_in   = PH_HEADER;
               hdr_cnt_in = '0;
               size_in    = '0;
               csum_in    = '0;
            end else if (digits_ff >= DIGITS_FULL) begin
               // entry full: ignore everything but newline
            end else if (rx_byte == CH_ETX) begin
               entered_in = '0;
               digits_in  = '0;
               hdr_cnt_in = '0;
               result.event_res = sbir_pkg::EV_ABORT;
            end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
               if (digits_ff != '0) begin
                  digits_in  = digits_ff - 1'b1;
                  entered_in = {4'd0, entered_ff[31:4]};
               end
            end else if (hex_ok) begin
               entered_in = {entered_ff[27:0], hex_val};
               digits_in  = digits_ff + 1'b1;
            end
         end
         PH_HEADER: begin
            if (!hdr_cnt_ff[2]) begin
               size_in = hdr_shift;
            end else begin
               csum_in = hdr_shift;
            end
            hdr_cnt_in = hdr_cnt_ff + 1'b1;
            // last header byte: size sanity and zero-size report
            if (hdr_cnt_ff == 3'd7) begin
               if (size_in[31]) begin
                  size_in = '0;
               end
               pay_cnt_in = '0;
               if (size_in == '0) begin
                  if (csum_in == '0) begin
                     result.event_res      = sbir_pkg::EV_START;
                     result.target_address = entered_ff;
                  end else begin
                     result.event_res = sbir_pkg::EV_FAIL;
                  end
                  phase_in   = PH_ENTRY;
                  entered_in = '0;
                  digits_in  = '0;
                  hdr_cnt_in = '0;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result.event_res      = sbir_pkg::EV_STORE;
            result.target_address = entered_ff + pay_cnt_ff;
            result.store_data     = rx_byte;
            csum_in    = csum_ff - {24'd0, rx_byte};
            pay_cnt_in = pay_cnt_ff + 32'd1;
            if (pay_cnt_in >= size_ff) begin
               phase_in = PH_REPORT;
            end
         end
         PH_REPORT: begin
            if (csum_ff == '0) begin
               result.event_res      = sbir_pkg::EV_START;
               result.target_address = entered_ff;
            end else begin
               result.event_res = sbir_pkg::EV_FAIL;
            end
            phase_in   = PH_ENTRY;
            entered_in = '0;
            digits_in  = '0;
            hdr_cnt_in = '0;
         end
         default: begin
            phase_in = PH_ENTRY;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ENTRY;
         entered_ff <= '0;
         digits_ff  <= '0;
         hdr_cnt_ff <= '0;
         size_ff    <= '0;
         csum_ff    <= '0;
         pay_cnt_ff <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         entered_ff <= entered_in;
         digits_ff  <= digits_in;
         hdr_cnt_ff <= hdr_cnt_in;
         size_ff    <= size_in;
         csum_ff    <= csum_in;
         pay_cnt_ff <= pay_cnt_in;
      end
   end

endmodule
